// ===== sv/chk_pkg.sv =====
// Shared constants and codes for the chained hash key cache.
package chk_pkg;

	localparam int DEF_BUCKETS      = 256;
	localparam int DEF_POOL_NODES   = 512;
	localparam int DEF_MAX_KEY_SEGS = 4;

	localparam int SEG_W     = 32;
	localparam int IN_SEGS   = 4;
	localparam int HANDLE_W  = 16;
	localparam int STATUS_W  = 2;
	localparam int CFG_W     = 3;

	localparam logic OP_INSERT = 1'b0;
	localparam logic OP_FIND   = 1'b1;

	localparam logic [STATUS_W-1:0] ST_INSERTED  = 2'd0;
	localparam logic [STATUS_W-1:0] ST_FOUND     = 2'd1;
	localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd2;
	localparam logic [STATUS_W-1:0] ST_FULL      = 2'd3;

endpackage

// ===== sv/chk_req_if.sv =====
// Request channel carrying one cache command with its key and handle.
interface chk_req_if import chk_pkg::*; ();
	logic                valid;
	logic                ready;
	logic                opcode;
	logic [SEG_W-1:0]    key_seg0;
	logic [SEG_W-1:0]    key_seg1;
	logic [SEG_W-1:0]    key_seg2;
	logic [SEG_W-1:0]    key_seg3;
	logic [HANDLE_W-1:0] entry_handle;

	modport source (output valid, opcode, key_seg0, key_seg1, key_seg2, key_seg3,
		entry_handle, input ready);
	modport sink (input valid, opcode, key_seg0, key_seg1, key_seg2, key_seg3,
		entry_handle, output ready);
endinterface

// ===== sv/chk_rsp_if.sv =====
// Response channel carrying the status and handle of one command.
interface chk_rsp_if import chk_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [STATUS_W-1:0] status;
	logic [HANDLE_W-1:0] found_handle;

	modport source (output valid, status, found_handle, input ready);
	modport sink (input valid, status, found_handle, output ready);
endinterface

// ===== sv/chk_ram.sv =====
// Generic simple dual-port RAM with one write port and a registered read port.
module chk_ram import chk_pkg::*; #(
	parameter int WIDTH = HANDLE_W,
	parameter int DEPTH = DEF_POOL_NODES,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

// ===== sv/chk_mod.sv =====
// Remainder unit that reduces a 32-bit hash modulo the bucket count by reciprocal multiplication.
module chk_mod import chk_pkg::*; #(
	parameter int BUCKETS = DEF_BUCKETS,
	localparam int BW = $clog2(BUCKETS)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [SEG_W-1:0] value,
	output logic             done,
	output logic [BW-1:0]    rem
);
	localparam logic [SEG_W-1:0] BK    = SEG_W'(BUCKETS);
	localparam logic [SEG_W-1:0] RECIP = SEG_W'((64'd1 << SEG_W) / 64'(BUCKETS));

	localparam logic [1:0] M_IDLE = 2'd0;
	localparam logic [1:0] M_MUL  = 2'd1;
	localparam logic [1:0] M_SUB  = 2'd2;
	localparam logic [1:0] M_FIX  = 2'd3;

	logic [1:0]         phase_q;
	logic               done_q;
	logic [SEG_W-1:0]   val_q;
	logic [SEG_W-1:0]   quo_q;
	logic [SEG_W-1:0]   diff_q;
	logic [BW-1:0]      rem_q;
	logic [2*SEG_W-1:0] prod;
	logic [SEG_W-1:0]   back;
	logic [SEG_W-1:0]   fixed;

	// The estimated quotient is low by at most one, so one compare and subtract finishes.
	assign prod  = (2*SEG_W)'(val_q) * (2*SEG_W)'(RECIP);
	assign back  = quo_q * BK;
	assign fixed = (diff_q >= BK) ? (diff_q - BK) : diff_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= M_IDLE;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (phase_q)
				M_IDLE: begin
					if (start) begin
						phase_q <= M_MUL;
					end
				end
				M_MUL: begin
					phase_q <= M_SUB;
				end
				M_SUB: begin
					phase_q <= M_FIX;
				end
				M_FIX: begin
					phase_q <= M_IDLE;
					done_q  <= 1'b1;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			val_q <= value;
		end
		if (phase_q == M_MUL) begin
			quo_q <= prod[2*SEG_W-1:SEG_W];
		end
		if (phase_q == M_SUB) begin
			diff_q <= val_q - back;
		end
		if (phase_q == M_FIX) begin
			rem_q <= fixed[BW-1:0];
		end
	end

	assign done = done_q;
	assign rem  = rem_q;
endmodule

// ===== sv/chained_hash_key_cache.sv =====
// Chained hash key cache: sequencer, bucket head table and node pool.
//
// Commands arrive on the req channel and each gives exactly one transfer on
// the rsp channel. An insert pushes a new node with the key and handle at the
// head of its bucket chain, or reports pool full. A find walks the chain from
// newest to oldest node and returns the first matching handle or not found.
// The cfg port sets how many 32-bit key segments take part in hash and compare.
// One command is in work at a time and req.ready is low meanwhile. A command
// passes the three-stage reciprocal remainder unit, then reads its bucket head,
// which an insert rewrites; a find then reads one chain node per cycle from
// the pool memory until a key matches or the chain ends. An insert into a
// full pool skips the bucket head and answers with pool full.
// The result sits in an output register, so the next command is taken while
// a stalled result still waits for rsp.ready; a finished command then waits
// until that register frees.
// After reset the block clears the bucket head table, one bucket per cycle,
// with req.ready low meanwhile; the pool starts empty.
module chained_hash_key_cache import chk_pkg::*; #(
	parameter int BUCKETS      = DEF_BUCKETS,
	parameter int POOL_NODES   = DEF_POOL_NODES,
	parameter int MAX_KEY_SEGS = DEF_MAX_KEY_SEGS
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [CFG_W-1:0] cfg_wdata,
	chk_req_if.sink          req,
	chk_rsp_if.source        rsp
);
	localparam int BW     = $clog2(BUCKETS);
	localparam int IW     = $clog2(POOL_NODES);
	localparam int NW     = $clog2(POOL_NODES + 1);
	localparam int KW     = MAX_KEY_SEGS * SEG_W;
	localparam int NODE_W = NW + HANDLE_W + KW;

	localparam logic [2:0] S_CLEAR = 3'd0;
	localparam logic [2:0] S_IDLE  = 3'd1;
	localparam logic [2:0] S_HASH  = 3'd2;
	localparam logic [2:0] S_HEAD  = 3'd3;
	localparam logic [2:0] S_NODE  = 3'd4;
	localparam logic [2:0] S_DONE  = 3'd5;

	logic [2:0]              state_q;
	logic [CFG_W-1:0]        key_segments_q;
	logic [BW-1:0]           clr_q;
	logic [NW-1:0]           used_q;
	logic                    op_q;
	logic [KW-1:0]           key_q;
	logic [HANDLE_W-1:0]     handle_q;
	logic [MAX_KEY_SEGS-1:0] seg_mask_q;
	logic [BW-1:0]           bucket_q;
	logic [STATUS_W-1:0]     st_q;
	logic [HANDLE_W-1:0]     hd_q;
	logic                    out_valid_q;
	logic [STATUS_W-1:0]     out_status_q;
	logic [HANDLE_W-1:0]     out_handle_q;

	logic [SEG_W-1:0]        in_seg [IN_SEGS];
	logic [KW-1:0]           key_in;
	logic [MAX_KEY_SEGS-1:0] seg_mask;
	logic [SEG_W-1:0]        hash;
	logic                    accept;
	logic                    mod_done;
	logic [BW-1:0]           mod_rem;
	logic                    head_we;
	logic [BW-1:0]           head_waddr;
	logic [NW-1:0]           head_wdata;
	logic [BW-1:0]           head_raddr;
	logic [NW-1:0]           head_rdata;
	logic                    node_we;
	logic [IW-1:0]           node_waddr;
	logic [NODE_W-1:0]       node_wdata;
	logic [IW-1:0]           node_raddr;
	logic [NODE_W-1:0]       node_rdata;
	logic [KW-1:0]           nd_key;
	logic [HANDLE_W-1:0]     nd_handle;
	logic [NW-1:0]           nd_next;
	logic [NW-1:0]           cur_m1;
	logic                    mism;
	logic                    pool_full;
	logic                    out_load;

	assign in_seg[0] = req.key_seg0;
	assign in_seg[1] = req.key_seg1;
	assign in_seg[2] = req.key_seg2;
	assign in_seg[3] = req.key_seg3;

	for (genvar i = 0; i < MAX_KEY_SEGS; i++) begin : g_seg
		if (i < IN_SEGS) begin : g_in
			assign key_in[i*SEG_W +: SEG_W] = in_seg[i];
		end else begin : g_zero
			assign key_in[i*SEG_W +: SEG_W] = '0;
		end
		assign seg_mask[i] = (i == 0) || (i < int'(key_segments_q));
	end

	always_comb begin
		hash = '0;
		for (int i = 0; i < MAX_KEY_SEGS; i++) begin
			if (seg_mask[i]) begin
				hash = hash ^ key_in[i*SEG_W +: SEG_W];
			end
		end
	end

	assign accept    = (state_q == S_IDLE) && req.valid;
	assign req.ready = (state_q == S_IDLE);
	assign pool_full = (used_q >= NW'(POOL_NODES));
	assign out_load  = (state_q == S_DONE) && (!out_valid_q || rsp.ready);

	chk_mod #(.BUCKETS(BUCKETS)) u_mod (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (accept),
		.value  (hash),
		.done   (mod_done),
		.rem    (mod_rem)
	);

	assign nd_key    = node_rdata[KW-1:0];
	assign nd_handle = node_rdata[KW +: HANDLE_W];
	assign nd_next   = node_rdata[NODE_W-1 -: NW];

	always_comb begin
		mism = 1'b0;
		for (int i = 0; i < MAX_KEY_SEGS; i++) begin
			if (seg_mask_q[i] && (nd_key[i*SEG_W +: SEG_W] != key_q[i*SEG_W +: SEG_W])) begin
				mism = 1'b1;
			end
		end
	end

	always_comb begin
		head_we    = 1'b0;
		head_waddr = bucket_q;
		head_wdata = '0;
		head_raddr = mod_rem;
		if (state_q == S_CLEAR) begin
			head_we    = 1'b1;
			head_waddr = clr_q;
		end else if ((state_q == S_HEAD) && (op_q == OP_INSERT)) begin
			head_we    = 1'b1;
			head_wdata = used_q + 1'b1;
		end
	end

	assign node_we    = (state_q == S_HEAD) && (op_q == OP_INSERT);
	assign node_waddr = used_q[IW-1:0];
	assign node_wdata = {head_rdata, handle_q, key_q};
	assign cur_m1     = ((state_q == S_HEAD) ? head_rdata : nd_next) - NW'(1);
	assign node_raddr = cur_m1[IW-1:0];

	chk_ram #(.WIDTH(NW), .DEPTH(BUCKETS)) u_head_ram (
		.clk   (clk),
		.we    (head_we),
		.waddr (head_waddr),
		.wdata (head_wdata),
		.raddr (head_raddr),
		.rdata (head_rdata)
	);

	chk_ram #(.WIDTH(NODE_W), .DEPTH(POOL_NODES)) u_node_ram (
		.clk   (clk),
		.we    (node_we),
		.waddr (node_waddr),
		.wdata (node_wdata),
		.raddr (node_raddr),
		.rdata (node_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_CLEAR;
			clr_q          <= '0;
			used_q         <= '0;
			key_segments_q <= CFG_W'(1);
			out_valid_q    <= 1'b0;
		end else begin
			if (cfg_we) begin
				key_segments_q <= cfg_wdata;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == BW'(BUCKETS - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (req.valid) begin
						state_q <= S_HASH;
					end
				end
				S_HASH: begin
					if (mod_done) begin
						if ((op_q == OP_INSERT) && pool_full) begin
							state_q <= S_DONE;
						end else begin
							state_q <= S_HEAD;
						end
					end
				end
				S_HEAD: begin
					if (op_q == OP_INSERT) begin
						used_q  <= used_q + 1'b1;
						state_q <= S_DONE;
					end else if (head_rdata == '0) begin
						state_q <= S_DONE;
					end else begin
						state_q <= S_NODE;
					end
				end
				S_NODE: begin
					if (!mism || (nd_next == '0)) begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (out_load) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q       <= req.opcode;
			key_q      <= key_in;
			handle_q   <= req.entry_handle;
			seg_mask_q <= seg_mask;
		end
		if ((state_q == S_HASH) && mod_done) begin
			bucket_q <= mod_rem;
			st_q     <= ST_FULL;
			hd_q     <= '0;
		end
		if (state_q == S_HEAD) begin
			st_q <= (op_q == OP_INSERT) ? ST_INSERTED : ST_NOT_FOUND;
			hd_q <= '0;
		end
		if (state_q == S_NODE) begin
			if (!mism) begin
				st_q <= ST_FOUND;
				hd_q <= nd_handle;
			end else begin
				st_q <= ST_NOT_FOUND;
				hd_q <= '0;
			end
		end
		if (out_load) begin
			out_status_q <= st_q;
			out_handle_q <= hd_q;
		end
	end

	assign rsp.valid        = out_valid_q;
	assign rsp.status       = out_status_q;
	assign rsp.found_handle = out_handle_q;

	a_node_room: assert property (@(posedge clk) disable iff (!arst_n)
		node_we |-> (used_q < NW'(POOL_NODES)))
		else $error("node written with the pool already used up");

	a_mod_in_hash: assert property (@(posedge clk) disable iff (!arst_n)
		mod_done |-> (state_q == S_HASH))
		else $error("remainder finished outside the hash state");

	a_handle_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_load && (st_q != ST_FOUND)) |-> (hd_q == '0))
		else $error("nonzero handle with a status other than found");

	a_used_step: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == S_HEAD) && (op_q == OP_INSERT)) |=>
			(used_q == NW'($past(used_q) + 1'b1)))
		else $error("pool count did not advance on insert");
endmodule
